@@ rtl/pid_hysteresis_heater_control_assert.svh @@
// Assertion macros shared by the heater controller RTL.
// No dependencies; included by the modules that carry checks.
`ifndef PID_HYSTERESIS_HEATER_CONTROL_ASSERT_SVH
`define PID_HYSTERESIS_HEATER_CONTROL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define PHHC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("phhc: assertion failed");

// Next-cycle implication, checked outside reset
`define PHHC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("phhc: assertion failed");

`else

`define PHHC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define PHHC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

@@ rtl/phhc_pkg.sv @@
// Shared types and constants of the heater controller.
// No dependencies; imported by every module of the block.
package phhc_pkg;

  // Fixed-point formats
  localparam int TEMP_FRAC_BITS = 5;
  localparam int GAIN_FRAC_BITS = 8;

  // Temperature reported when the sensor read failed (about -3.16 degrees)
  localparam logic signed [15:0] SENTINEL_TEMP = -16'sd101;

  // Drive thresholds of the switching rule
  localparam logic signed [31:0] DRIVE_OFF_MAX = 32'(3 << TEMP_FRAC_BITS);
  localparam logic signed [31:0] DRIVE_ON_MIN  = 32'(((1 << TEMP_FRAC_BITS) + 5) / 10);

  // Signed 32-bit saturation limits
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // PID accumulator width: sum of three products
  localparam int ACC_W = 51;

  // Mode codes of the request
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_CTRL  = 2'd1;
  localparam logic [1:0] MODE_FORCE_ON  = 2'd2;
  localparam logic [1:0] MODE_FORCE_OFF = 2'd3;

  // Operation after classification
  typedef enum logic [1:0] {
    OP_POLL = 2'd0,
    OP_CTRL = 2'd1,
    OP_ON   = 2'd2,
    OP_OFF  = 2'd3
  } op_t;

  // Queue entry between front and back
  typedef struct packed {
    op_t                op;
    logic signed [15:0] temp;
    logic               touch_edge;
  } q_item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result of one request
  typedef struct packed {
    logic               heater_on;
    logic signed [31:0] drive_value;
    logic               loop_enabled;
    logic signed [15:0] temperature_used;
  } res_t;

  // Configuration registers
  typedef struct packed {
    logic signed [15:0] target_temperature;
    logic [15:0]        gain_proportional;
    logic [15:0]        gain_integral;
    logic [15:0]        gain_derivative;
    logic [11:0]        off_band;
    logic [11:0]        on_band;
    logic               touch_reenables;
  } cfg_t;

  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFF_BAND  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ON_BAND   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TOUCH_REN = 3'd6;

  localparam logic signed [15:0] RST_TARGET = 16'sd0;
  localparam logic [15:0]        RST_GAIN_P = 16'd307;
  localparam logic [15:0]        RST_GAIN_I = 16'd179;
  localparam logic [15:0]        RST_GAIN_D = 16'd614;
  localparam logic [11:0]        RST_OFF_BAND = 12'd96;
  localparam logic [11:0]        RST_ON_BAND  = 12'd3;

endpackage

@@ rtl/phhc_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
// No dependencies; used by the top level and the front module.
interface phhc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] temperature;
  logic               temp_valid;
  logic               touch_level;

  modport source (output valid, mode, temperature, temp_valid, touch_level, input ready);
  modport sink   (input valid, mode, temperature, temp_valid, touch_level, output ready);
endinterface

interface phhc_out_if;
  logic               valid;
  logic               ready;
  logic               heater_on;
  logic signed [31:0] drive_value;
  logic               loop_enabled;
  logic signed [15:0] temperature_used;

  modport source (output valid, heater_on, drive_value, loop_enabled, temperature_used,
                  input ready);
  modport sink   (input valid, heater_on, drive_value, loop_enabled, temperature_used,
                  output ready);
endinterface

@@ rtl/pid_hysteresis_heater_control.sv @@
// Top level of the PID heater controller with hysteresis switching.
// Depends on phhc_pkg, phhc_ifs, phhc_regs, phhc_front, phhc_queue, phhc_back.
//
// Usage:
//  - in_ch carries one request per tick: mode, temperature, temp_valid,
//    touch_level. out_ch returns exactly one result per request, in order.
//  - Configuration is written through the APB-style port (psel/penable/
//    pwrite/paddr/pwdata); register i sits at byte address 4*i. pready is
//    always high; reads return the register value.
//  - Path: a request accepted into an empty queue goes through the queue,
//    stage 1 (error), stage 2 (products) and the result register (drive).
//  - Throughput: one request per cycle while out_ch is not stalled. A request
//    that carries a rising touch edge waits at the queue head until the two
//    arithmetic stages ahead of it have drained, because the loop enable it
//    sets depends on the heater state those stages produce.
//  - Stall: while a result waits and out_ch.ready is low the back end
//    holds; the front keeps taking requests into a two-entry queue until
//    it fills, then drops in_ch.ready.
//  - Reset (rst_n low, synchronous): heater off, loop enabled, integral,
//    last error, last temperature and last drive cleared, registers back
//    to their defaults, queue and pipeline emptied.
module pid_hysteresis_heater_control (
  input  logic                            clk,
  input  logic                            rst_n,
  phhc_in_if.sink                         in_ch,
  phhc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [phhc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import phhc_pkg::*;

  cfg_t    cfg;
  logic    push, q_full, pop, head_vld, out_vld;
  q_item_t push_item, head_item;
  res_t    out_item;

  phhc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  phhc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_vld  (head_vld),
    .head_item (head_item)
  );

  phhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_vld  (head_vld),
    .head_item (head_item),
    .pop       (pop),
    .out_ready (out_ch.ready),
    .out_vld   (out_vld),
    .out_item  (out_item)
  );

  // Drive the result channel
  assign out_ch.valid            = out_vld;
  assign out_ch.heater_on        = out_item.heater_on;
  assign out_ch.drive_value      = out_item.drive_value;
  assign out_ch.loop_enabled     = out_item.loop_enabled;
  assign out_ch.temperature_used = out_item.temperature_used;

endmodule

@@ rtl/phhc_front.sv @@
// Front end: accepts requests, substitutes the sentinel, detects touch edges.
// Depends on phhc_pkg and phhc_in_if; feeds phhc_queue.
module phhc_front (
  input  logic              clk,
  input  logic              rst_n,
  phhc_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output phhc_pkg::q_item_t push_item
);
  import phhc_pkg::*;

  logic last_touch_r;
  logic last_touch_nxt;
  logic accept;

  // Take a request whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept;

  // Classify the request
  always_comb begin
    push_item.temp       = in_ch.temp_valid ? in_ch.temperature : SENTINEL_TEMP;
    push_item.touch_edge = in_ch.touch_level && !last_touch_r;
    case (in_ch.mode)
      MODE_POLL:      push_item.op = OP_POLL;
      MODE_CTRL:      push_item.op = OP_CTRL;
      MODE_FORCE_ON:  push_item.op = OP_ON;
      MODE_FORCE_OFF: push_item.op = OP_OFF;
      default:        push_item.op = OP_POLL;
    endcase
  end

  // Track the touch pad level of the last accepted request
  assign last_touch_nxt = accept ? in_ch.touch_level : last_touch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_touch_r <= 1'b0;
    end else begin
      last_touch_r <= last_touch_nxt;
    end
  end

endmodule

@@ rtl/phhc_queue.sv @@
// Short FIFO that decouples the front end from the arithmetic back end.
// Depends on phhc_pkg for the entry type and depth.
module phhc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  phhc_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_vld,
  output phhc_pkg::q_item_t head_item
);
  import phhc_pkg::*;

`include "pid_hysteresis_heater_control_assert.svh"

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PHHC_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(QUEUE_DEPTH))
  `PHHC_ASSERT_IMPL(a_q_pop_nonempty, clk, rst_n, pop, head_vld)
  `PHHC_ASSERT_IMPL(a_q_push_room, clk, rst_n, push, !full)

endmodule

@@ rtl/phhc_regs.sv @@
// APB-style configuration registers of the heater controller.
// Depends on phhc_pkg for the register map and the cfg_t bundle.
module phhc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [phhc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output phhc_pkg::cfg_t                  cfg
);
  import phhc_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TARGET:    cfg_nxt.target_temperature = pwdata[15:0];
        REG_GAIN_P:    cfg_nxt.gain_proportional  = pwdata[15:0];
        REG_GAIN_I:    cfg_nxt.gain_integral      = pwdata[15:0];
        REG_GAIN_D:    cfg_nxt.gain_derivative    = pwdata[15:0];
        REG_OFF_BAND:  cfg_nxt.off_band           = pwdata[11:0];
        REG_ON_BAND:   cfg_nxt.on_band            = pwdata[11:0];
        REG_TOUCH_REN: cfg_nxt.touch_reenables    = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temperature <= RST_TARGET;
      cfg_r.gain_proportional  <= RST_GAIN_P;
      cfg_r.gain_integral      <= RST_GAIN_I;
      cfg_r.gain_derivative    <= RST_GAIN_D;
      cfg_r.off_band           <= RST_OFF_BAND;
      cfg_r.on_band            <= RST_ON_BAND;
      cfg_r.touch_reenables    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_TARGET:    prdata = {{16{cfg_r.target_temperature[15]}}, cfg_r.target_temperature};
      REG_GAIN_P:    prdata = {16'd0, cfg_r.gain_proportional};
      REG_GAIN_I:    prdata = {16'd0, cfg_r.gain_integral};
      REG_GAIN_D:    prdata = {16'd0, cfg_r.gain_derivative};
      REG_OFF_BAND:  prdata = {20'd0, cfg_r.off_band};
      REG_ON_BAND:   prdata = {20'd0, cfg_r.on_band};
      REG_TOUCH_REN: prdata = {31'd0, cfg_r.touch_reenables};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/phhc_back.sv @@
// Back end: error update, PID products, drive and heater switching, result register.
// Depends on phhc_pkg; pops phhc_queue and drives the result channel.
module phhc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  phhc_pkg::cfg_t    cfg,
  input  logic              head_vld,
  input  phhc_pkg::q_item_t head_item,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_vld,
  output phhc_pkg::res_t    out_item
);
  import phhc_pkg::*;

`include "pid_hysteresis_heater_control_assert.svh"

  typedef struct packed {
    logic               ctrl;
    op_t                op;
    logic               touch_edge;
    logic               loop_en;
    logic signed [15:0] temp;
    logic signed [15:0] last_temp;
    logic signed [16:0] err;
    logic signed [31:0] esum;
    logic signed [17:0] deriv;
  } s1_t;

  typedef struct packed {
    logic               ctrl;
    op_t                op;
    logic               touch_edge;
    logic               loop_en;
    logic signed [15:0] temp;
    logic signed [15:0] last_temp;
    logic signed [33:0] p_prop;
    logic signed [48:0] p_int;
    logic signed [34:0] p_der;
  } s2_t;

  // Loop state
  logic               loop_en_r, loop_en_nxt;
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic signed [16:0] last_err_r;
  logic signed [15:0] last_temp_r;
  logic               heater_state_r, heater_nxt;
  logic signed [31:0] last_drive_r;

  // Pipeline
  s1_t  st1_r;
  logic st1_vld_r;
  s2_t  st2_r;
  logic st2_vld_r;
  res_t out_r;
  logic out_vld_r;

  logic               adv;
  logic               hazard;
  logic               s1_ctrl;
  logic signed [16:0] err_c;
  logic [32:0]        sum_c;
  logic signed [17:0] deriv_c;

  logic signed [16:0] kp_s, ki_s, kd_s;
  logic signed [33:0] p_prop_c;
  logic signed [48:0] p_int_c;
  logic signed [34:0] p_der_c;

  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W-1:0] shifted_c;
  logic [ACC_W-32:0]       hi_c;
  logic signed [31:0]      drive_nxt;
  logic signed [17:0]      temp_x, lim_off, lim_on;

  // Move the whole back end when the result slot frees up
  assign adv     = !out_vld_r || out_ready;
  assign hazard  = head_item.touch_edge && (st1_vld_r || st2_vld_r);
  assign pop     = adv && head_vld && !hazard;
  assign out_vld = out_vld_r;
  assign out_item = out_r;

  // Stage 1: touch effect on the loop enable, error and integral update
  always_comb begin
    loop_en_nxt = loop_en_r;
    if (head_item.touch_edge) begin
      if (heater_state_r) begin
        loop_en_nxt = 1'b0;
      end else if (cfg.touch_reenables) begin
        loop_en_nxt = 1'b1;
      end
    end
    s1_ctrl = (head_item.op == OP_CTRL) && loop_en_nxt;

    err_c = {cfg.target_temperature[15], cfg.target_temperature}
          - {head_item.temp[15], head_item.temp};
    sum_c = {{16{err_c[16]}}, err_c} + {error_sum_r[31], error_sum_r};
    if (sum_c[32] != sum_c[31]) begin
      error_sum_nxt = sum_c[32] ? SAT_MIN : SAT_MAX;
    end else begin
      error_sum_nxt = sum_c[31:0];
    end
    deriv_c = {err_c[16], err_c} - {last_err_r[16], last_err_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_en_r   <= 1'b1;
      error_sum_r <= '0;
      last_err_r  <= '0;
      last_temp_r <= '0;
    end else if (pop) begin
      loop_en_r <= loop_en_nxt;
      if (s1_ctrl) begin
        error_sum_r <= error_sum_nxt;
        last_err_r  <= err_c;
        last_temp_r <= head_item.temp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st1_r.ctrl       <= s1_ctrl;
      st1_r.op         <= head_item.op;
      st1_r.touch_edge <= head_item.touch_edge;
      st1_r.loop_en    <= loop_en_nxt;
      st1_r.temp       <= head_item.temp;
      st1_r.last_temp  <= last_temp_r;
      st1_r.err        <= err_c;
      st1_r.esum       <= error_sum_nxt;
      st1_r.deriv      <= deriv_c;
    end
  end

  // Stage 2: three gain products in parallel
  assign kp_s     = $signed({1'b0, cfg.gain_proportional});
  assign ki_s     = $signed({1'b0, cfg.gain_integral});
  assign kd_s     = $signed({1'b0, cfg.gain_derivative});
  assign p_prop_c = kp_s * st1_r.err;
  assign p_int_c  = ki_s * st1_r.esum;
  assign p_der_c  = kd_s * st1_r.deriv;

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_r.ctrl       <= st1_r.ctrl;
      st2_r.op         <= st1_r.op;
      st2_r.touch_edge <= st1_r.touch_edge;
      st2_r.loop_en    <= st1_r.loop_en;
      st2_r.temp       <= st1_r.temp;
      st2_r.last_temp  <= st1_r.last_temp;
      st2_r.p_prop     <= p_prop_c;
      st2_r.p_int      <= p_int_c;
      st2_r.p_der      <= p_der_c;
    end
  end

  // Stage 3: sum, floor shift and saturate the drive
  always_comb begin
    acc_c = {{(ACC_W-34){st2_r.p_prop[33]}}, st2_r.p_prop}
          + {{(ACC_W-49){st2_r.p_int[48]}}, st2_r.p_int}
          + {{(ACC_W-35){st2_r.p_der[34]}}, st2_r.p_der};
    shifted_c = acc_c >>> GAIN_FRAC_BITS;
    hi_c      = shifted_c[ACC_W-1:31];
    if (hi_c == '0 || hi_c == '1) begin
      drive_nxt = shifted_c[31:0];
    end else begin
      drive_nxt = hi_c[ACC_W-32] ? SAT_MIN : SAT_MAX;
    end
  end

  // Stage 3: touch toggle, hysteresis switching, forced commands
  assign temp_x  = {{2{st2_r.temp[15]}}, st2_r.temp};
  assign lim_off = {{2{cfg.target_temperature[15]}}, cfg.target_temperature}
                 - {6'd0, cfg.off_band};
  assign lim_on  = {{2{cfg.target_temperature[15]}}, cfg.target_temperature}
                 - {6'd0, cfg.on_band};

  always_comb begin
    heater_nxt = heater_state_r;
    if (st2_r.touch_edge) begin
      heater_nxt = !heater_nxt;
    end
    case (st2_r.op)
      OP_CTRL: begin
        if (st2_r.ctrl) begin
          if (temp_x >= lim_off && st2_r.last_temp <= st2_r.temp && heater_nxt
              && drive_nxt <= DRIVE_OFF_MAX) begin
            heater_nxt = 1'b0;
          end
          if (temp_x <= lim_on && st2_r.last_temp >= st2_r.temp && !heater_nxt
              && drive_nxt >= DRIVE_ON_MIN) begin
            heater_nxt = 1'b1;
          end
        end
      end
      OP_ON:   heater_nxt = 1'b1;
      OP_OFF:  heater_nxt = 1'b0;
      default: heater_nxt = heater_nxt;
    endcase
  end

  // Pipeline valids and state that retires with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r      <= 1'b0;
      st2_vld_r      <= 1'b0;
      out_vld_r      <= 1'b0;
      heater_state_r <= 1'b0;
      last_drive_r   <= '0;
    end else if (adv) begin
      st1_vld_r <= pop;
      st2_vld_r <= st1_vld_r;
      out_vld_r <= st2_vld_r;
      if (st2_vld_r) begin
        heater_state_r <= heater_nxt;
        if (st2_r.ctrl) begin
          last_drive_r <= drive_nxt;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv && st2_vld_r) begin
      out_r.heater_on        <= heater_nxt;
      out_r.drive_value      <= st2_r.ctrl ? drive_nxt : last_drive_r;
      out_r.loop_enabled     <= st2_r.loop_en;
      out_r.temperature_used <= st2_r.temp;
    end
  end

  `PHHC_ASSERT_IMPL(a_touch_drained, clk, rst_n, pop && head_item.touch_edge, !st1_vld_r && !st2_vld_r)
  `PHHC_ASSERT_NEXT(a_loop_hold, clk, rst_n, !(pop && head_item.touch_edge), $stable(loop_en_r))
  `PHHC_ASSERT_NEXT(a_touch_off, clk, rst_n, pop && head_item.touch_edge && heater_state_r, !loop_en_r)
  `PHHC_ASSERT_NEXT(a_sum_hold, clk, rst_n, !(pop && s1_ctrl), $stable(error_sum_r))

endmodule

@@ verif/heater_scoreboard_pkg.sv @@
// Scoreboard for the heater controller: a cycle-free model of the control law
// and an in-order store of the heater status reports it predicts.
// Depends on phhc_pkg for the result type, mode codes and register indexes.
package heater_scoreboard_pkg;
  import phhc_pkg::*;

  class heater_scoreboard;
    // Register copies
    int goal;
    int gain_p;
    int gain_i;
    int gain_d;
    int band_off;
    int band_on;
    bit touch_enables;

    // Controller state
    bit heater;
    bit loop_on;
    bit touch_prev;
    int err_sum;
    int err_prev;
    int temp_prev;
    int drive_prev;

    // Reports still owed by the block, oldest first
    res_t status_due[$];
    int requests_seen;
    int results_seen;
    int mismatches;

    function new();
      goal          = int'(RST_TARGET);
      gain_p        = int'(RST_GAIN_P);
      gain_i        = int'(RST_GAIN_I);
      gain_d        = int'(RST_GAIN_D);
      band_off      = int'(RST_OFF_BAND);
      band_on       = int'(RST_ON_BAND);
      touch_enables = 1'b0;
      heater        = 1'b0;
      loop_on       = 1'b1;
      touch_prev    = 1'b0;
      err_sum       = 0;
      err_prev      = 0;
      temp_prev     = 0;
      drive_prev    = 0;
      requests_seen = 0;
      results_seen  = 0;
      mismatches    = 0;
    endfunction

    // Clamp to the signed 32-bit range
    function longint clamp32(longint v);
      if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
      if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
      return v;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_TARGET:    goal          = int'($signed(value[15:0]));
        REG_GAIN_P:    gain_p        = int'(value[15:0]);
        REG_GAIN_I:    gain_i        = int'(value[15:0]);
        REG_GAIN_D:    gain_d        = int'(value[15:0]);
        REG_OFF_BAND:  band_off      = int'(value[11:0]);
        REG_ON_BAND:   band_on       = int'(value[11:0]);
        REG_TOUCH_REN: touch_enables = value[0];
        default: ;
      endcase
    endfunction

    // Advance the controller by one accepted request and queue its report
    function void note_request(logic [1:0] mode, logic signed [15:0] temp_in,
                               logic temp_ok, logic touch);
      int     t;
      int     err;
      int     deriv;
      longint acc;
      res_t   r;
      t = temp_ok ? int'(temp_in) : int'(SENTINEL_TEMP);

      // Touch edge toggles the heater before the mode is looked at
      if (touch && !touch_prev) begin
        if (!heater) begin
          heater = 1'b1;
          if (touch_enables) loop_on = 1'b1;
        end else begin
          heater  = 1'b0;
          loop_on = 1'b0;
        end
      end
      touch_prev = touch;

      if (mode == MODE_CTRL && loop_on) begin
        err     = goal - t;
        deriv   = err - err_prev;
        err_sum = int'(clamp32(longint'(err_sum) + longint'(err)));
        acc = longint'(gain_p) * err + longint'(gain_i) * err_sum
            + longint'(gain_d) * deriv;
        // Arithmetic shift floors toward minus infinity
        drive_prev = int'(clamp32(acc >>> GAIN_FRAC_BITS));
        // Off check first, then on check: both may fire on one sample
        if (t >= goal - band_off && temp_prev <= t && heater && drive_prev <= DRIVE_OFF_MAX)
          heater = 1'b0;
        if (t <= goal - band_on && temp_prev >= t && !heater && drive_prev >= DRIVE_ON_MIN)
          heater = 1'b1;
        err_prev  = err;
        temp_prev = t;
      end else if (mode == MODE_FORCE_ON) begin
        heater = 1'b1;
      end else if (mode == MODE_FORCE_OFF) begin
        heater = 1'b0;
      end

      r.heater_on        = heater;
      r.drive_value      = drive_prev;
      r.loop_enabled     = loop_on;
      r.temperature_used = 16'(t);
      status_due.push_back(r);
      requests_seen++;
    endfunction

    // Compare one report from the block with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: heater %0d drive %0d loop %0d temp %0d",
                   got.heater_on, got.drive_value, got.loop_enabled, got.temperature_used);
        return;
      end
      want = status_due.pop_front();
      if (got.heater_on !== want.heater_on || got.drive_value !== want.drive_value ||
          got.loop_enabled !== want.loop_enabled ||
          got.temperature_used !== want.temperature_used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d: want heater %0d drive %0d loop %0d temp %0d, got %0d %0d %0d %0d",
                   results_seen, want.heater_on, want.drive_value, want.loop_enabled,
                   want.temperature_used, got.heater_on, got.drive_value,
                   got.loop_enabled, got.temperature_used);
      end
    endfunction
  endclass

endpackage

@@ verif/testbench.sv @@
// Top-level bench for the heater controller: drives requests and APB writes,
// stalls the result side at random and checks every report in order.
// Depends on phhc_pkg, phhc_ifs, heater_scoreboard_pkg and the block's RTL.
module testbench;
  import phhc_pkg::*;
  import heater_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 135;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  phhc_in_if  in_ch ();
  phhc_out_if out_ch ();

  heater_scoreboard sb;
  int idle_level;
  int stall_left;
  int cycles;
  int settings_count;

  pid_hysteresis_heater_control i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: none at level 0, else mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (idle_level == 0) return 0;
    r = $urandom_range(99);
    if (r < ((idle_level == 1) ? 75 : 45)) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // Stall the result side at random
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (idle_level == 0) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left   = pick_gap();
      end
    end
  end

  // Check each report as it is taken
  always @(posedge clk) begin : watch_reports
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.heater_on        = out_ch.heater_on;
      got.drive_value      = out_ch.drive_value;
      got.loop_enabled     = out_ch.loop_enabled;
      got.temperature_used = out_ch.temperature_used;
      sb.check_result(got);
    end
  end

  // End the run if the block hangs
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one request; hold it until taken. Entered and left just after a falling edge.
  task automatic push_request(logic [1:0] mode, logic signed [15:0] temp, logic temp_ok,
                              logic touch);
    int gap;
    bit taken;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = mode;
    in_ch.temperature = temp;
    in_ch.temp_valid  = temp_ok;
    in_ch.touch_level = touch;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ch.ready;
    end
    sb.note_request(mode, temp, temp_ok, touch);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drop valid and wait until every report is back, plus pipeline slack
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Press the pad until the loop comes back on; touch re-enable must be set
  task automatic ensure_loop();
    while (!sb.loop_on) begin
      push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
      push_request(MODE_POLL, 16'sd0, 1'b1, 1'b0);
    end
  endtask

  // Write every register, leave the loop enabled
  task automatic apply_config(int goal, int kp, int ki, int kd, int boff, int bon, bit ren);
    drain();
    apb_write(REG_TARGET, 32'(goal));
    apb_write(REG_GAIN_P, 32'(kp));
    apb_write(REG_GAIN_I, 32'(ki));
    apb_write(REG_GAIN_D, 32'(kd));
    apb_write(REG_OFF_BAND, 32'(boff));
    apb_write(REG_ON_BAND, 32'(bon));
    apb_write(REG_TOUCH_REN, 32'd1);
    ensure_loop();
    if (!ren) begin
      drain();
      apb_write(REG_TOUCH_REN, 32'd0);
    end
    settings_count++;
  endtask

  // Random request, biased toward control samples near the goal
  task automatic random_request(int touch_pct);
    int         r;
    int         t;
    logic [1:0] mode;
    logic       temp_ok;
    logic       touch;
    r = $urandom_range(99);
    mode = (r < 70) ? MODE_CTRL : (r < 80) ? MODE_POLL : (r < 90) ? MODE_FORCE_ON
                                                                  : MODE_FORCE_OFF;
    r = $urandom_range(99);
    if (r < 60) begin
      t = sb.goal - 300 + int'($urandom_range(400));
      t = (t < -6400) ? -6400 : (t > 27200) ? 27200 : t;
    end else if (r < 70) begin
      t = ($urandom_range(1) == 0) ? -6400 : 27200;
    end else begin
      t = int'($urandom_range(33600)) - 6400;
    end
    temp_ok = ($urandom_range(99) >= 8);
    touch   = in_ch.touch_level ^ ($urandom_range(99) < touch_pct);
    push_request(mode, 16'(t), temp_ok, touch);
  endtask

  initial begin
    int  ph;
    bit  ren;
    sb                = new();
    settings_count    = 1;
    idle_level        = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_POLL;
    in_ch.temperature = 16'sd0;
    in_ch.temp_valid  = 1'b0;
    in_ch.touch_level = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, sentinel, every mode, touch cases at reset settings
    push_request(MODE_CTRL, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_CTRL, -16'sd6400, 1'b1, 1'b0);
    push_request(MODE_CTRL, 16'sd27200, 1'b1, 1'b0);
    push_request(MODE_CTRL, 16'sd27200, 1'b0, 1'b0);
    push_request(MODE_POLL, -16'sd6400, 1'b0, 1'b0);
    push_request(MODE_FORCE_ON, 16'sd100, 1'b1, 1'b0);
    push_request(MODE_FORCE_OFF, 16'sd100, 1'b1, 1'b0);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_CTRL, -16'sd200, 1'b1, 1'b1);
    push_request(MODE_CTRL, -16'sd300, 1'b1, 1'b0);
    push_request(MODE_FORCE_ON, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
    push_request(MODE_FORCE_OFF, 16'sd0, 1'b1, 1'b0);

    // Directed: unit proportional gain so one sample turns the heater off and on again
    apply_config(0, 256, 0, 0, 96, 3, 1'b1);
    push_request(MODE_FORCE_ON, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_CTRL, -16'sd50, 1'b1, 1'b0);
    push_request(MODE_FORCE_ON, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_CTRL, -16'sd50, 1'b1, 1'b0);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b0);
    push_request(MODE_POLL, 16'sd0, 1'b1, 1'b1);

    // Random phases: register extremes first, then random settings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        ren = 1'b0;
        apply_config(-6400, 0, 0, 0, 0, 0, ren);
      end else if (ph == 1) begin
        ren = 1'b1;
        apply_config(27200, 65535, 65535, 65535, 3200, 3200, ren);
      end else begin
        ren = $urandom_range(1);
        apply_config(int'($urandom_range(33600)) - 6400,
                     ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1024),
                     ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1024),
                     ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1024),
                     ($urandom_range(3) == 0) ? $urandom_range(3200) : $urandom_range(160),
                     ($urandom_range(3) == 0) ? $urandom_range(3200) : $urandom_range(160),
                     ren);
      end
      idle_level = (ph % 4 == 3) ? 0 : 1 + ph % 2;
      repeat (PHASE_ITEMS) random_request(ren ? 6 : 2);
    end

    // Close with a short burst under heavy idling on both sides
    idle_level = 2;
    repeat (40) random_request(4);

    drain();
    $display("Ran %0d requests under %0d register settings with random stalls.",
             sb.requests_seen, settings_count);
    $display("Checked %0d reports: %0d mismatches, %0d never returned.",
             sb.results_seen, sb.mismatches, sb.status_due.size());
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/phhc_pkg.sv
rtl/phhc_ifs.sv
rtl/phhc_front.sv
rtl/phhc_queue.sv
rtl/phhc_regs.sv
rtl/phhc_back.sv
rtl/pid_hysteresis_heater_control.sv
verif/heater_scoreboard_pkg.sv
verif/testbench.sv
